FILE: hw/rtl/isr_pkg.sv
// Package for the indexed stack with remove: sizes, operation codes,
// status codes and the control bundle broadcast to the entry cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package isr_pkg;

	localparam int CAPACITY   = 128;
	localparam int WORD_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int MODE_W     = 3;
	localparam int POS_W      = 7;
	localparam int OUT_WORD_W = 32;
	localparam int OUT_CNT_W  = 8;
	localparam int STATUS_W   = 2;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND = 3'd0,
		MODE_POP    = 3'd1,
		MODE_READ   = 3'd2,
		MODE_WRITE  = 3'd3,
		MODE_REMOVE = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic                  append_en;
		logic                  write_en;
		logic                  remove_en;
		logic [IDX_W-1:0]      pos;
		logic [CNT_W-1:0]      count;
		logic [WORD_WIDTH-1:0] word;
	} cell_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/isr_cell.sv
// One entry cell of the list: holds a word, loads a new word on append or
// write at its index, or takes its upper neighbor's word on a remove.
// Depends on isr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module isr_cell (
	input  wire                          clk,
	input  wire  [isr_pkg::IDX_W-1:0]    idx,
	input  wire  isr_pkg::cell_ctrl_t    ctrl,
	input  wire  [isr_pkg::WORD_WIDTH-1:0] next_word,
	output logic [isr_pkg::WORD_WIDTH-1:0] word
);
	import isr_pkg::*;

	logic [WORD_WIDTH-1:0] word_q;
	logic                  load_new;
	logic                  shift_in;
	logic [CNT_W-1:0]      idx_next;

	assign idx_next = CNT_W'(idx) + CNT_W'(1);
	assign load_new = (ctrl.append_en && (CNT_W'(idx) == ctrl.count)) ||
	                  (ctrl.write_en && (idx == ctrl.pos));
	assign shift_in = ctrl.remove_en && (idx >= ctrl.pos) && (idx_next < ctrl.count);

	always_ff @(posedge clk) begin
		if (load_new) begin
			word_q <= ctrl.word;
		end else if (shift_in) begin
			word_q <= next_word;
		end
	end

	assign word = word_q;

endmodule
`default_nettype wire

FILE: hw/rtl/indexed_stack_with_remove_core.sv
// Top level of the indexed stack with remove: decodes each beat, drives a
// chain of isr_cell entry cells and registers the result beat.
// Depends on isr_pkg and isr_cell.
//
//   channel   direction  tdata bits (low to high)
//   s_axis    in         mode[2:0], position[9:3], word_in[41:10], zero[47:42]
//   m_axis    out        word_out[31:0], entry_count[39:32], status[41:40], zero[47:42]
//
// Every operation finishes in the cycle its beat is accepted; the remove
// shifts all later cells down by one place in that same cycle.
// The result appears in the output register in the cycle after the beat is accepted.
// A new beat is taken whenever the output register is empty or being drained,
// so the throughput is one beat per cycle while m_axis_tready is high.
// Reset empties the list; cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module indexed_stack_with_remove_core (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_axis_tvalid,
	output logic                            s_axis_tready,
	// mode, position, word_in, zero padding
	input  wire  [isr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  wire                             m_axis_tready,
	// word_out, entry_count, status, zero padding
	output logic [isr_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import isr_pkg::*;

	logic [MODE_W-1:0]     in_mode;
	logic [POS_W-1:0]      in_pos;
	logic [WORD_WIDTH-1:0] in_word;
	logic                  accept;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic [CNT_W-1:0]      pos_ext;
	logic                  pos_ok;
	logic                  is_full;
	logic                  is_empty;
	logic [IDX_W-1:0]      rd_addr;
	logic [WORD_WIDTH-1:0] rd_word;
	logic [WORD_WIDTH-1:0] res_word;
	status_t               res_status;
	cell_ctrl_t            ctrl;
	logic [WORD_WIDTH-1:0] cell_word [CAPACITY];

	logic                  out_valid_q;
	logic [WORD_WIDTH-1:0] word_out_q;
	logic [CNT_W-1:0]      count_out_q;
	status_t               status_q;

	assign in_mode = s_axis_tdata[MODE_W-1:0];
	assign in_pos  = s_axis_tdata[MODE_W +: POS_W];
	assign in_word = s_axis_tdata[MODE_W + POS_W +: WORD_WIDTH];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign pos_ext  = CNT_W'(in_pos);
	assign pos_ok   = pos_ext < count_q;
	assign is_full  = count_q == CNT_W'(CAPACITY);
	assign is_empty = count_q == '0;

	always_comb begin
		res_word   = '0;
		res_status = ST_OK;
		count_nxt  = count_q;
		rd_addr    = IDX_W'(in_pos);
		ctrl       = '0;
		ctrl.pos   = IDX_W'(in_pos);
		ctrl.count = count_q;
		ctrl.word  = in_word;
		case (in_mode)
			MODE_APPEND: begin
				if (is_full) begin
					res_status = ST_FULL;
				end else begin
					ctrl.append_en = accept;
					count_nxt      = count_q + CNT_W'(1);
				end
			end
			MODE_POP: begin
				rd_addr = IDX_W'(count_q - CNT_W'(1));
				if (is_empty) begin
					res_status = ST_EMPTY;
				end else begin
					res_word  = rd_word;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			MODE_READ: begin
				if (!pos_ok) begin
					res_status = ST_RANGE;
				end else begin
					res_word = rd_word;
				end
			end
			MODE_WRITE: begin
				if (!pos_ok) begin
					res_status = ST_RANGE;
				end else begin
					ctrl.write_en = accept;
				end
			end
			MODE_REMOVE: begin
				if (!pos_ok) begin
					res_status = ST_RANGE;
				end else begin
					res_word       = rd_word;
					ctrl.remove_en = accept;
					count_nxt      = count_q - CNT_W'(1);
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	assign rd_word = cell_word[rd_addr];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] upper;
		if (i == CAPACITY - 1) begin : g_top
			assign upper = '0;
		end else begin : g_mid
			assign upper = cell_word[i + 1];
		end
		isr_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(i)),
			.ctrl      (ctrl),
			.next_word (upper),
			.word      (cell_word[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_out_q  <= res_word;
			count_out_q <= count_nxt;
			status_q    <= res_status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		(OUT_DATA_W - OUT_WORD_W - OUT_CNT_W - STATUS_W)'(0),
		status_q,
		OUT_CNT_W'(count_out_q),
		OUT_WORD_W'(word_out_q)
	};

endmodule
`default_nettype wire
